// File: hw/rtl/ibfp_pkg.sv
// Package for the frame parser: sizes, frame constants, register map and
// the structs passed between the parser modules. No dependencies.
package ibfp_pkg;

  localparam int unsigned FRAME_BYTES  = 32;
  localparam int unsigned SUM_BYTES    = 30;
  localparam int unsigned NUM_CHANNELS = 14;
  localparam int unsigned ADDR_W       = $clog2(FRAME_BYTES);
  localparam int unsigned FILL_W       = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CH_W         = 4;
  localparam int unsigned VAL_W        = 16;

  localparam logic [7:0] HDR0 = 8'h20;
  localparam logic [7:0] HDR1 = 8'h40;

  localparam int unsigned PADDR_W = 4;
  localparam logic [PADDR_W-1:0] REG_CH_MIN  = 4'h0;
  localparam logic [PADDR_W-1:0] REG_CH_MAX  = 4'h4;
  localparam logic [PADDR_W-1:0] REG_TIMEOUT = 4'h8;

  localparam logic [VAL_W-1:0] CH_MIN_RST  = 16'd1000;
  localparam logic [VAL_W-1:0] CH_MAX_RST  = 16'd2000;
  localparam logic [VAL_W-1:0] TIMEOUT_RST = 16'd100;

  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_TICK = 1'b1;
  localparam logic RES_CHANNEL = 1'b0;
  localparam logic RES_STATUS  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLIDE0,
    ST_SLIDE30,
    ST_CHK0,
    ST_CHK1,
    ST_CHK30,
    ST_EVAL,
    ST_EMIT_LO,
    ST_EMIT_HI,
    ST_EMIT_OUT,
    ST_TICK_OUT
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0] ch_min;
    logic [VAL_W-1:0] ch_max;
    logic [VAL_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             result_kind;
    logic [CH_W-1:0]  channel_index;
    logic [VAL_W-1:0] channel_value;
    logic             last;
    logic             connected;
  } res_t;

endpackage

// File: hw/rtl/ibfp_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ibfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ibfp_ctrl.sv
// Parser sequencer: keeps the byte window as a ring in the window RAM, checks
// for frames and walks out the channel values. Depends on ibfp_pkg.
module ibfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ibfp_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_kind_i,
  input  logic [7:0]          in_byte_i,
  output ibfp_pkg::mem_req_t  mem_req_o,
  input  logic [7:0]          mem_rdata_i,
  output logic                res_valid_o,
  output ibfp_pkg::res_t      res_o,
  input  logic                slot_free_i
);

  localparam int unsigned AW = ibfp_pkg::ADDR_W;
  localparam int unsigned FW = ibfp_pkg::FILL_W;
  localparam int unsigned VW = ibfp_pkg::VAL_W;
  localparam int unsigned CW = ibfp_pkg::CH_W;

  ibfp_pkg::state_e state_q, state_d;

  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [VW-1:0] sum_q, sum_d;
  logic          slide_q, slide_d;
  logic [7:0]    byte_q, byte_d;
  logic [7:0]    old0_q, old0_d;
  logic [7:0]    hdr0_q, hdr0_d;
  logic [7:0]    hdr1_q, hdr1_d;
  logic [7:0]    lo_q, lo_d;
  logic [CW-1:0] ch_q, ch_d;
  logic          seen_q, seen_d;
  logic [VW-1:0] ticks_q, ticks_d;

  logic          accept;
  logic [AW-1:0] chk_base;
  logic [AW-1:0] lo_addr;
  logic          frame_ok;
  logic          last_ch;
  logic          link_up;
  logic [VW-1:0] raw_val;
  logic [VW-1:0] clamp_lo;
  logic [VW-1:0] clamp_val;

  assign in_ready_o = (state_q == ibfp_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // After a slide the new window starts one entry past the old head.
  assign chk_base = head_q + AW'(slide_q);
  assign lo_addr  = head_q + AW'({ch_q, 1'b0}) + AW'(2);
  assign last_ch  = (ch_q == CW'(ibfp_pkg::NUM_CHANNELS - 1));
  assign link_up  = seen_q && (ticks_q < cfg_i.timeout);

  // The checksum word is {window[31], window[30]}; window[31] is the new byte.
  assign frame_ok = (hdr0_q == ibfp_pkg::HDR0) && (hdr1_q == ibfp_pkg::HDR1) &&
                    ({byte_q, mem_rdata_i} == ~sum_q);

  assign raw_val   = {mem_rdata_i, lo_q};
  assign clamp_lo  = (raw_val < cfg_i.ch_min) ? cfg_i.ch_min : raw_val;
  assign clamp_val = (clamp_lo > cfg_i.ch_max) ? cfg_i.ch_max : clamp_lo;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ibfp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == ibfp_pkg::IN_TICK) begin
            state_d = ibfp_pkg::ST_TICK_OUT;
          end else if (fill_q == FW'(ibfp_pkg::FRAME_BYTES)) begin
            state_d = ibfp_pkg::ST_SLIDE0;
          end else if (fill_q == FW'(ibfp_pkg::FRAME_BYTES - 1)) begin
            state_d = ibfp_pkg::ST_CHK0;
          end
        end
      end
      ibfp_pkg::ST_SLIDE0:  state_d = ibfp_pkg::ST_SLIDE30;
      ibfp_pkg::ST_SLIDE30: state_d = ibfp_pkg::ST_CHK0;
      ibfp_pkg::ST_CHK0:    state_d = ibfp_pkg::ST_CHK1;
      ibfp_pkg::ST_CHK1:    state_d = ibfp_pkg::ST_CHK30;
      ibfp_pkg::ST_CHK30:   state_d = ibfp_pkg::ST_EVAL;
      ibfp_pkg::ST_EVAL: begin
        state_d = frame_ok ? ibfp_pkg::ST_EMIT_LO : ibfp_pkg::ST_IDLE;
      end
      ibfp_pkg::ST_EMIT_LO: state_d = ibfp_pkg::ST_EMIT_HI;
      ibfp_pkg::ST_EMIT_HI: state_d = ibfp_pkg::ST_EMIT_OUT;
      ibfp_pkg::ST_EMIT_OUT: begin
        if (slot_free_i) begin
          state_d = last_ch ? ibfp_pkg::ST_IDLE : ibfp_pkg::ST_EMIT_LO;
        end
      end
      ibfp_pkg::ST_TICK_OUT: begin
        if (slot_free_i) begin
          state_d = ibfp_pkg::ST_IDLE;
        end
      end
      default: state_d = ibfp_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory requests and results.
  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    slide_d     = slide_q;
    byte_d      = byte_q;
    old0_d      = old0_q;
    hdr0_d      = hdr0_q;
    hdr1_d      = hdr1_q;
    lo_d        = lo_q;
    ch_d        = ch_q;
    seen_d      = seen_q;
    ticks_d     = ticks_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      ibfp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == ibfp_pkg::IN_TICK) begin
            if (ticks_q != '1) begin
              ticks_d = ticks_q + VW'(1);
            end
          end else begin
            byte_d = in_byte_i;
            if (fill_q == FW'(ibfp_pkg::FRAME_BYTES)) begin
              // Window full: the write of the new byte waits until the old
              // oldest entry has been read.
              slide_d = 1'b1;
            end else begin
              slide_d         = 1'b0;
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = head_q + fill_q[AW-1:0];
              mem_req_o.wdata = in_byte_i;
              fill_d          = fill_q + FW'(1);
              if (fill_q < FW'(ibfp_pkg::SUM_BYTES)) begin
                sum_d = sum_q + VW'(in_byte_i);
              end
            end
          end
        end
      end
      ibfp_pkg::ST_SLIDE0: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = head_q;
      end
      ibfp_pkg::ST_SLIDE30: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = head_q + AW'(ibfp_pkg::SUM_BYTES);
        old0_d          = mem_rdata_i;
      end
      ibfp_pkg::ST_CHK0: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = chk_base;
        if (slide_q) begin
          sum_d = sum_q - VW'(old0_q) + VW'(mem_rdata_i);
        end
      end
      ibfp_pkg::ST_CHK1: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = chk_base + AW'(1);
        hdr0_d          = mem_rdata_i;
      end
      ibfp_pkg::ST_CHK30: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = chk_base + AW'(ibfp_pkg::SUM_BYTES);
        hdr1_d          = mem_rdata_i;
      end
      ibfp_pkg::ST_EVAL: begin
        // The new byte replaces the old oldest entry, which becomes the
        // newest place in the ring.
        mem_req_o.we    = slide_q;
        mem_req_o.waddr = head_q;
        mem_req_o.wdata = byte_q;
        head_d          = chk_base;
        fill_d          = FW'(ibfp_pkg::FRAME_BYTES);
        if (frame_ok) begin
          fill_d  = '0;
          sum_d   = '0;
          seen_d  = 1'b1;
          ticks_d = '0;
          ch_d    = '0;
        end
      end
      ibfp_pkg::ST_EMIT_LO: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = lo_addr;
      end
      ibfp_pkg::ST_EMIT_HI: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = lo_addr + AW'(1);
        lo_d            = mem_rdata_i;
      end
      ibfp_pkg::ST_EMIT_OUT: begin
        res_valid_o         = 1'b1;
        res_o.result_kind   = ibfp_pkg::RES_CHANNEL;
        res_o.channel_index = ch_q;
        res_o.channel_value = clamp_val;
        res_o.last          = last_ch;
        res_o.connected     = link_up;
        if (slot_free_i) begin
          ch_d = ch_q + CW'(1);
        end
      end
      ibfp_pkg::ST_TICK_OUT: begin
        res_valid_o         = 1'b1;
        res_o.result_kind   = ibfp_pkg::RES_STATUS;
        res_o.last          = 1'b1;
        res_o.connected     = link_up;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibfp_pkg::ST_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      seen_q  <= 1'b0;
      ticks_q <= '0;
      ch_q    <= '0;
      slide_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      seen_q  <= seen_d;
      ticks_q <= ticks_d;
      ch_q    <= ch_d;
      slide_q <= slide_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    old0_q <= old0_d;
    hdr0_q <= hdr0_d;
    hdr1_q <= hdr1_d;
    lo_q   <= lo_d;
  end

endmodule

// File: hw/rtl/ibus_frame_parser_top.sv
// Top level of the serial frame parser: configuration registers, the output
// register and the window RAM. Depends on ibfp_pkg, ibfp_ram and ibfp_ctrl.
//
// Usage: the input stream carries one item per received byte (tuser = 0,
// tdata = the byte) or per timer tick (tuser = 1). The output stream carries
// channel results of a good frame (tuser = 0) and one status result per tick
// (tuser = 1); tlast marks the final result caused by an input item.
// Input is taken only while the parser is idle. A byte into a window that is not
// yet full needs no RAM read, and the byte that fills it waits for the three
// check reads. Once the window holds 32 bytes, each byte waits for the five
// reads of the single read port of the window RAM. A good frame then emits 14
// results, with two RAM reads per channel.
// Reset clears the window fill, the checksum sum, the link status and the
// registers to their defaults (min 1000, max 2000, timeout 100); no RAM
// clearing is needed, so items are taken right after reset.
// A stalled output holds its item in the output register; the parser stops at
// its next result until the register frees up, and input waits meanwhile.
// Registers (APB, byte addresses): 0x0 channel_min, 0x4 channel_max,
// 0x8 timeout_ticks; write them only while the block is idle.
module ibus_frame_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input item stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tuser,  // [0] kind
  // Result item stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] channel_index, [19:4] channel_value, [20] connected, [23:21] zero
  output logic [23:0]                   m_axis_tdata,
  output logic                          m_axis_tuser,  // [0] result_kind
  output logic                          m_axis_tlast,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned VW = ibfp_pkg::VAL_W;

  ibfp_pkg::cfg_t     cfg_q;
  ibfp_pkg::mem_req_t mem_req;
  ibfp_pkg::res_t     res;
  ibfp_pkg::res_t     out_q;
  logic               out_valid_q;
  logic               res_valid;
  logic               slot_free;
  logic [7:0]         mem_rdata;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ch_min  <= ibfp_pkg::CH_MIN_RST;
      cfg_q.ch_max  <= ibfp_pkg::CH_MAX_RST;
      cfg_q.timeout <= ibfp_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (paddr)
        ibfp_pkg::REG_CH_MIN:  cfg_q.ch_min  <= pwdata[VW-1:0];
        ibfp_pkg::REG_CH_MAX:  cfg_q.ch_max  <= pwdata[VW-1:0];
        ibfp_pkg::REG_TIMEOUT: cfg_q.timeout <= pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ibfp_pkg::REG_CH_MIN:  prdata = {{(32-VW){1'b0}}, cfg_q.ch_min};
      ibfp_pkg::REG_CH_MAX:  prdata = {{(32-VW){1'b0}}, cfg_q.ch_max};
      ibfp_pkg::REG_TIMEOUT: prdata = {{(32-VW){1'b0}}, cfg_q.timeout};
      default:               prdata = '0;
    endcase
  end

  ibfp_ram #(
    .WIDTH (8),
    .DEPTH (ibfp_pkg::FRAME_BYTES)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  ibfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .slot_free_i (slot_free)
  );

  // Output register: a new result may load in the cycle the old one leaves.
  assign slot_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.connected, out_q.channel_value, out_q.channel_index};
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tlast  = out_q.last;

endmodule

// File: tb/ibus_frame_parser_top_test.sv
// Self-checking testbench for ibus_frame_parser_top: streams bytes and ticks
// through the block and checks every result against an in-bench frame decoder.
// Depends on ibfp_pkg and the RTL of ibus_frame_parser_top.
module ibus_frame_parser_top_test;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam logic [ibfp_pkg::PADDR_W-1:0] REG_UNMAPPED = 4'hC;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rx_item_t;

  typedef enum {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_BAD_CHECKSUM} frame_flaw_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;   // [7:0] data_byte
  logic                          s_axis_tuser = 1'b0; // [0] kind
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [3:0] channel_index, [19:4] channel_value, [20] connected, [23:21] zero
  logic [23:0]                   m_axis_tdata;
  logic                          m_axis_tuser;        // [0] result_kind
  logic                          m_axis_tlast;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ibfp_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  ibus_frame_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Decoder state and register mirror.
  logic [7:0]                 win_bytes [ibfp_pkg::FRAME_BYTES];
  logic [5:0]                 win_fill = '0;
  logic [15:0]                win_sum = '0;
  logic                       link_seen = 1'b0;
  logic [15:0]                tick_count = '0;
  logic [ibfp_pkg::VAL_W-1:0] lim_min = ibfp_pkg::CH_MIN_RST;
  logic [ibfp_pkg::VAL_W-1:0] lim_max = ibfp_pkg::CH_MAX_RST;
  logic [ibfp_pkg::VAL_W-1:0] link_timeout = ibfp_pkg::TIMEOUT_RST;

  rx_item_t        rx_items [$];
  ibfp_pkg::res_t  decoded_results [$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned frames_found = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  initial begin
    for (int i = 0; i < ibfp_pkg::FRAME_BYTES; i++) win_bytes[i] = '0;
  end

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still pending", $time,
               cycle_count, decoded_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic link_up();
    return link_seen && (tick_count < link_timeout);
  endfunction

  // Applies one accepted item to the decoder and queues the results it causes.
  task automatic decode_rx_item(input logic kind, input logic [7:0] data);
    logic [15:0]    frame_chk;
    logic [15:0]    ch_val;
    ibfp_pkg::res_t r;
    if (kind == ibfp_pkg::IN_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      r.result_kind   = ibfp_pkg::RES_STATUS;
      r.channel_index = '0;
      r.channel_value = '0;
      r.last          = 1'b1;
      r.connected     = link_up();
      decoded_results.push_back(r);
    end else begin
      if (win_fill < ibfp_pkg::FRAME_BYTES) begin
        if (win_fill < ibfp_pkg::SUM_BYTES) win_sum = win_sum + data;
        win_bytes[win_fill[4:0]] = data;
        win_fill++;
      end else begin
        win_sum = win_sum - win_bytes[0] + win_bytes[ibfp_pkg::SUM_BYTES];
        for (int i = 0; i < ibfp_pkg::FRAME_BYTES - 1; i++) win_bytes[i] = win_bytes[i+1];
        win_bytes[ibfp_pkg::FRAME_BYTES-1] = data;
      end
      frame_chk = {win_bytes[ibfp_pkg::SUM_BYTES+1], win_bytes[ibfp_pkg::SUM_BYTES]};
      if (win_fill == ibfp_pkg::FRAME_BYTES && win_bytes[0] == ibfp_pkg::HDR0 &&
          win_bytes[1] == ibfp_pkg::HDR1 && frame_chk == 16'hFFFF - win_sum) begin
        frames_found++;
        link_seen  = 1'b1;
        tick_count = '0;
        for (int i = 0; i < ibfp_pkg::NUM_CHANNELS; i++) begin
          ch_val = {win_bytes[3+2*i], win_bytes[2+2*i]};
          // Lower clamp first, so a minimum above the maximum yields the maximum.
          if (ch_val < lim_min) ch_val = lim_min;
          if (ch_val > lim_max) ch_val = lim_max;
          r.result_kind   = ibfp_pkg::RES_CHANNEL;
          r.channel_index = ibfp_pkg::CH_W'(i);
          r.channel_value = ch_val;
          r.last          = (i == ibfp_pkg::NUM_CHANNELS - 1);
          r.connected     = link_up();
          decoded_results.push_back(r);
        end
        for (int i = 0; i < ibfp_pkg::FRAME_BYTES; i++) win_bytes[i] = '0;
        win_fill = '0;
        win_sum  = '0;
      end
    end
  endtask

  always @(posedge clk_i) begin : drive_rx
    rx_item_t next_item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_rx_item(s_axis_tuser, s_axis_tdata);
        items_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = rx_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_item.kind;
          s_axis_tdata  <= next_item.data;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    ibfp_pkg::res_t got;
    ibfp_pkg::res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.result_kind   = m_axis_tuser;
        got.channel_index = m_axis_tdata[3:0];
        got.channel_value = m_axis_tdata[19:4];
        got.last          = m_axis_tlast;
        got.connected     = m_axis_tdata[20];
        if (decoded_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result kind=%0d ch=%0d value=%0d last=%0d conn=%0d",
                     $time, got.result_kind, got.channel_index, got.channel_value,
                     got.last, got.connected);
        end else begin
          want = decoded_results.pop_front();
          results_checked++;
          if (got.result_kind !== want.result_kind ||
              got.channel_index !== want.channel_index ||
              got.channel_value !== want.channel_value ||
              got.last !== want.last || got.connected !== want.connected) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"%0t: result mismatch: expected kind=%0d ch=%0d value=%0d last=%0d",
                        " conn=%0d, got kind=%0d ch=%0d value=%0d last=%0d conn=%0d"},
                       $time, want.result_kind, want.channel_index, want.channel_value,
                       want.last, want.connected, got.result_kind, got.channel_index,
                       got.channel_value, got.last, got.connected);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic queue_rx(input logic kind, input logic [7:0] data);
    rx_item_t item;
    item.kind = kind;
    item.data = data;
    rx_items.push_back(item);
    items_queued++;
  endtask

  // Builds one 32-byte frame around the given channel words; ticks may be
  // slipped in between bytes since they leave the window alone.
  task automatic queue_frame(input logic [16*ibfp_pkg::NUM_CHANNELS-1:0] vals,
                             input frame_flaw_e flaw, input int unsigned tick_pct);
    logic [7:0]  fb [ibfp_pkg::FRAME_BYTES];
    logic [15:0] sum;
    logic [15:0] chk;
    fb[0] = ibfp_pkg::HDR0;
    fb[1] = ibfp_pkg::HDR1;
    for (int i = 0; i < ibfp_pkg::NUM_CHANNELS; i++) begin
      fb[2+2*i] = vals[16*i +: 8];
      fb[3+2*i] = vals[16*i+8 +: 8];
    end
    if (flaw == FRAME_BAD_HEADER) fb[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
    sum = '0;
    for (int i = 0; i < ibfp_pkg::SUM_BYTES; i++) sum = sum + fb[i];
    chk = 16'hFFFF - sum;
    if (flaw == FRAME_BAD_CHECKSUM) chk ^= 16'($urandom_range(1, 65535));
    fb[ibfp_pkg::SUM_BYTES]   = chk[7:0];
    fb[ibfp_pkg::SUM_BYTES+1] = chk[15:8];
    for (int i = 0; i < ibfp_pkg::FRAME_BYTES; i++) begin
      if ($urandom_range(99) < tick_pct) queue_rx(ibfp_pkg::IN_TICK, 8'($urandom));
      queue_rx(ibfp_pkg::IN_BYTE, fb[i]);
    end
  endtask

  function automatic logic [15:0] pick_channel_value();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return lim_min;
      3: return lim_max;
      4: return lim_min - 16'd1;
      5: return lim_max + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames with random contents, plus broken frames,
  // loose bytes and ticks.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    logic [16*ibfp_pkg::NUM_CHANNELS-1:0] vals;
    start = items_queued;
    while (items_queued - start < count) begin
      pick = $urandom_range(99);
      for (int i = 0; i < ibfp_pkg::NUM_CHANNELS; i++) vals[16*i +: 16] = pick_channel_value();
      if (pick < 55) begin
        queue_frame(vals, FRAME_GOOD, 10);
      end else if (pick < 65) begin
        queue_frame(vals, FRAME_BAD_HEADER, 10);
      end else if (pick < 75) begin
        queue_frame(vals, FRAME_BAD_CHECKSUM, 10);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0: queue_rx(ibfp_pkg::IN_BYTE, ibfp_pkg::HDR0);
            1: queue_rx(ibfp_pkg::IN_BYTE, ibfp_pkg::HDR1);
            default: queue_rx(ibfp_pkg::IN_BYTE, 8'($urandom));
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 3)) queue_rx(ibfp_pkg::IN_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [ibfp_pkg::PADDR_W-1:0] addr,
                           input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      ibfp_pkg::REG_CH_MIN:  lim_min = value;
      ibfp_pkg::REG_CH_MAX:  lim_max = value;
      ibfp_pkg::REG_TIMEOUT: link_timeout = value;
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [ibfp_pkg::PADDR_W-1:0] addr,
                           input logic [15:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== want) begin
      error_count++;
      $display("%0t: register 0x%0h read mismatch: expected %0d, got %0d", $time, addr,
               want, prdata[15:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] min_val, input logic [15:0] max_val,
                           input logic [15:0] timeout_val);
    write_reg(ibfp_pkg::REG_CH_MIN, min_val);
    write_reg(ibfp_pkg::REG_CH_MAX, max_val);
    write_reg(ibfp_pkg::REG_TIMEOUT, timeout_val);
    // A write to an unmapped address must leave all registers alone.
    write_reg(REG_UNMAPPED, 16'($urandom));
    check_reg(ibfp_pkg::REG_CH_MIN, lim_min);
    check_reg(ibfp_pkg::REG_CH_MAX, lim_max);
    check_reg(ibfp_pkg::REG_TIMEOUT, link_timeout);
    settings_used++;
  endtask

  // Waits until every queued item is taken and every result is back, then lets a
  // byte that gave no result finish inside the block.
  task automatic wait_drained();
    while (items_accepted != items_queued || decoded_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : run_phases
    logic [16*ibfp_pkg::NUM_CHANNELS-1:0] vals;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(ibfp_pkg::REG_CH_MIN, lim_min);
    check_reg(ibfp_pkg::REG_CH_MAX, lim_max);
    check_reg(ibfp_pkg::REG_TIMEOUT, link_timeout);
    settings_used++;

    // Reset defaults: ticks before any frame, a false header that fails its
    // checksum, a misaligned window, then one frame hitting every clamp edge.
    queue_rx(ibfp_pkg::IN_TICK, 8'h00);
    queue_rx(ibfp_pkg::IN_TICK, 8'hFF);
    queue_rx(ibfp_pkg::IN_BYTE, ibfp_pkg::HDR0);
    queue_rx(ibfp_pkg::IN_BYTE, ibfp_pkg::HDR1);
    queue_rx(ibfp_pkg::IN_BYTE, 8'h00);
    vals = {16'd1, 16'h7FFF, 16'd1500, 16'hFF00, 16'h00FF, 16'h8000, 16'd2001,
            16'd2000, 16'd1999, 16'd1001, 16'd1000, 16'd999, 16'hFFFF, 16'h0000};
    queue_frame(vals, FRAME_GOOD, 0);
    queue_rx(ibfp_pkg::IN_TICK, 8'h5A);
    wait_drained();

    // Full-range clamps and the longest timeout.
    configure(16'h0000, 16'hFFFF, 16'hFFFF);
    queue_random_traffic(35);
    for (int i = 0; i < ibfp_pkg::NUM_CHANNELS; i++) vals[16*i +: 16] = 16'($urandom);
    queue_frame(vals, FRAME_GOOD, 0);
    repeat (3) queue_rx(ibfp_pkg::IN_TICK, 8'($urandom));
    wait_drained();

    // Minimum above maximum and a timeout of one tick, with a slow sender.
    sender_idle_pct = 82;
    configure(16'd3000, 16'd500, 16'd1);
    queue_random_traffic(35);
    wait_drained();

    // Default clamps and a zero timeout, with a stalling receiver.
    sender_idle_pct    = 0;
    receiver_stall_pct = 82;
    configure(16'd1000, 16'd2000, 16'd0);
    queue_random_traffic(35);
    wait_drained();

    sender_idle_pct    = 11;
    receiver_stall_pct = 11;
    configure(16'($urandom_range(0, 2000)), 16'($urandom_range(1000, 65535)),
              16'($urandom_range(1, 20)));
    queue_random_traffic(35);
    wait_drained();

    $display("Sent %0d items under %0d register settings and four idle patterns;",
             items_queued, settings_used);
    $display("checked %0d results, %0d of them from good frames (%0d frames).",
             results_checked, frames_found * ibfp_pkg::NUM_CHANNELS, frames_found);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
